/* rtl/sdtw_pkg.sv */
// sdtw_pkg: types, constants and ceiling-divide helpers for the sdram timing word calculator
// self-contained, no dependencies
package sdtw_pkg;

    typedef enum logic [2:0] {
        REG_ROW_BITS          = 3'd0,
        REG_CAS_CYCLES        = 3'd1,
        REG_CLOCK_PERIOD_NS   = 3'd2,
        REG_ACT_TO_RW_NS      = 3'd3,
        REG_PRECHARGE_NS      = 3'd4,
        REG_WRITE_RECOVERY_NS = 3'd5,
        REG_REFRESH_PERIOD_US = 3'd6,
        REG_EARLY_STEPPING    = 3'd7
    } t_reg_idx;

    localparam logic [31:0] CFG_KEEP_MASK = 32'h007f007f;
    localparam logic [31:0] REF_KEEP_MASK = 32'hffbffff0;
    localparam logic [31:0] REF_DRI_MASK  = 32'hffff000f;
    localparam logic [31:0] REF_LOW_NIB   = 32'h00000007;
    localparam logic [31:0] CAS_BASE      = 32'h55555555;
    localparam logic [31:0] CAS_BASE_ODD  = 32'haaaaaaaa;
    localparam logic [17:0] DELAY_KHZ     = 18'd62000;
    localparam logic [9:0]  NS_PER_US     = 10'd1000;

    // ceil(p / 1e6) = ceil(ceil(p / 64) / 15625), the last one by reciprocal
    localparam logic [22:0] RECIP_S   = 23'd4398047;     // ceil(2^36 / 15625)
    localparam int          RECIP_S_K = 36;
    localparam logic [31:0] RECIP_L   = 32'd2251799814;  // ceil(2^45 / 15625)
    localparam int          RECIP_L_K = 45;
    localparam logic [20:0] BIAS_S    = 21'd15624;
    localparam logic [30:0] BIAS_L    = 31'd15624;
    localparam logic [43:0] SAT_LIMIT = 44'd131071000000;

    function automatic logic [7:0] cyc_small(input logic [25:0] p);
        logic [26:0] t;
        logic [20:0] y;
        logic [43:0] prod;
        t    = {1'b0, p} + 27'd63;
        y    = t[26:6] + BIAS_S;
        prod = 44'(y) * 44'(RECIP_S);
        return prod[RECIP_S_K +: 8];
    endfunction

    function automatic logic [17:0] cyc_large(input logic [43:0] p);
        logic [44:0] t;
        logic [30:0] y;
        logic [62:0] prod;
        t    = {1'b0, p} + 45'd63;
        y    = t[36:6] + BIAS_L;
        prod = 63'(y) * 63'(RECIP_L);
        return prod[RECIP_L_K +: 18];
    endfunction

endpackage

/* rtl/sdram_timing_word_calculator_core.sv */
// sdram_timing_word_calculator_core: four-stage pipeline building the sdram timing words
// depends on sdtw_pkg
// an accepted request passes the capture, product, divide and assembly registers in turn, o_valid for one cycle
// throughput: one request per cycle; busy never rises, the receiver cannot stall
// stage 2 multiplies the timings by the memory clock, stage 3 divides by 10^6 via reciprocal
// synchronous reset clears the valid pipeline and restores the register defaults
module sdram_timing_word_calculator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [18:0] i_cpu_khz,
    input  logic [31:0] i_old_config_word,
    input  logic [31:0] i_old_refresh_word,
    output logic        o_valid,
    output logic [31:0] o_config_word,
    output logic [31:0] o_refresh_word,
    output logic [31:0] o_cas_pattern_0,
    output logic [31:0] o_cas_pattern_1,
    output logic [31:0] o_cas_pattern_2,
    output logic [11:0] o_refresh_interval,
    output logic        o_half_speed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdtw_pkg::*;

    logic [4:0]  r_row_bits;
    logic [1:0]  r_cas_cycles;
    logic [7:0]  r_clock_period_ns;
    logic [7:0]  r_act_to_rw_ns;
    logic [7:0]  r_precharge_ns;
    logic [7:0]  r_write_recovery_ns;
    logic [15:0] r_refresh_period_us;
    logic        r_early_stepping;
    logic [25:0] r_ns_row;
    logic [25:0] n_ns_row;
    logic        wr_en;
    t_reg_idx    reg_idx;

    logic        r_a_vld;
    logic [18:0] r_a_khz;
    logic [31:0] r_a_old_cfg;
    logic [31:0] r_a_old_ref;

    logic        r_b_vld;
    logic [17:0] r_b_mem;
    logic [25:0] r_b_p_ck;
    logic [25:0] r_b_p_wr;
    logic [25:0] r_b_p_pc;
    logic [25:0] r_b_p_rcd;
    logic [43:0] r_b_p_ref;
    logic [31:0] r_b_old_cfg;
    logic [31:0] r_b_old_ref;
    logic [17:0] n_b_mem;

    logic        r_c_vld;
    logic [17:0] r_c_mem;
    logic [7:0]  r_c_q_ck;
    logic [7:0]  r_c_q_wr;
    logic [7:0]  r_c_q_pc;
    logic [7:0]  r_c_q_rcd;
    logic [17:0] r_c_q_ref;
    logic        r_c_sat;
    logic [31:0] r_c_old_cfg;
    logic [31:0] r_c_old_ref;

    logic        n_half;
    logic [17:0] n_sd_khz;
    logic        n_delayed;
    logic [7:0]  n_trp;
    logic [31:0] n_cfg;
    logic [11:0] n_dri;
    logic [31:0] n_ref;
    logic [8:0]  n_r;
    logic [8:0]  n_shift;
    logic [31:0] n_ones;
    logic [31:0] n_cas0;
    logic [31:0] n_cas1;

    logic        r_out_vld;
    logic [31:0] r_out_cfg;
    logic [31:0] r_out_ref;
    logic [31:0] r_out_cas0;
    logic [31:0] r_out_cas1;
    logic [11:0] r_out_dri;
    logic        r_out_half;

    // configuration port
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bits          <= 5'd12;
            r_cas_cycles        <= 2'd3;
            r_clock_period_ns   <= 8'd8;
            r_act_to_rw_ns      <= 8'd20;
            r_precharge_ns      <= 8'd20;
            r_write_recovery_ns <= 8'd8;
            r_refresh_period_us <= 16'd64000;
            r_early_stepping    <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ROW_BITS:          r_row_bits          <= pwdata[4:0];
                REG_CAS_CYCLES:        r_cas_cycles        <= pwdata[1:0];
                REG_CLOCK_PERIOD_NS:   r_clock_period_ns   <= pwdata[7:0];
                REG_ACT_TO_RW_NS:      r_act_to_rw_ns      <= pwdata[7:0];
                REG_PRECHARGE_NS:      r_precharge_ns      <= pwdata[7:0];
                REG_WRITE_RECOVERY_NS: r_write_recovery_ns <= pwdata[7:0];
                REG_REFRESH_PERIOD_US: r_refresh_period_us <= pwdata[15:0];
                REG_EARLY_STEPPING:    r_early_stepping    <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROW_BITS:          prdata = {27'd0, r_row_bits};
            REG_CAS_CYCLES:        prdata = {30'd0, r_cas_cycles};
            REG_CLOCK_PERIOD_NS:   prdata = {24'd0, r_clock_period_ns};
            REG_ACT_TO_RW_NS:      prdata = {24'd0, r_act_to_rw_ns};
            REG_PRECHARGE_NS:      prdata = {24'd0, r_precharge_ns};
            REG_WRITE_RECOVERY_NS: prdata = {24'd0, r_write_recovery_ns};
            REG_REFRESH_PERIOD_US: prdata = {16'd0, r_refresh_period_us};
            REG_EARLY_STEPPING:    prdata = {31'd0, r_early_stepping};
        endcase
    end

    // nanoseconds per row, static between writes
    assign n_ns_row = (26'(r_refresh_period_us) * 26'(NS_PER_US)) >> r_row_bits;

    always_ff @(posedge i_clk) begin
        r_ns_row <= n_ns_row;
    end

    assign busy = 1'b0;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_a_vld   <= start && !busy;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_out_vld <= r_c_vld;
        end
    end

    // stage 1: capture request
    always_ff @(posedge i_clk) begin
        r_a_khz     <= i_cpu_khz;
        r_a_old_cfg <= i_old_config_word;
        r_a_old_ref <= i_old_refresh_word;
    end

    // stage 2: timing products with the memory clock
    assign n_b_mem = r_a_khz[18:1];

    always_ff @(posedge i_clk) begin
        r_b_mem     <= n_b_mem;
        r_b_p_ck    <= 26'(r_clock_period_ns) * 26'(n_b_mem);
        r_b_p_wr    <= 26'(r_write_recovery_ns) * 26'(n_b_mem);
        r_b_p_pc    <= 26'(r_precharge_ns) * 26'(n_b_mem);
        r_b_p_rcd   <= 26'(r_act_to_rw_ns) * 26'(n_b_mem);
        r_b_p_ref   <= 44'(r_ns_row) * 44'(n_b_mem);
        r_b_old_cfg <= r_a_old_cfg;
        r_b_old_ref <= r_a_old_ref;
    end

    // stage 3: round-up divide by 10^6
    always_ff @(posedge i_clk) begin
        r_c_mem     <= r_b_mem;
        r_c_q_ck    <= cyc_small(r_b_p_ck);
        r_c_q_wr    <= cyc_small(r_b_p_wr);
        r_c_q_pc    <= cyc_small(r_b_p_pc);
        r_c_q_rcd   <= cyc_small(r_b_p_rcd);
        r_c_q_ref   <= cyc_large(r_b_p_ref);
        r_c_sat     <= r_b_p_ref > SAT_LIMIT;
        r_c_old_cfg <= r_b_old_cfg;
        r_c_old_ref <= r_b_old_ref;
    end

    // stage 4: word assembly
    always_comb begin
        n_half    = ((r_c_q_ck > 8'd1) || (r_early_stepping && (r_c_mem < DELAY_KHZ)))
                    && (r_c_mem != 18'd0);
        n_sd_khz  = n_half ? {1'b0, r_c_mem[17:1]} : r_c_mem;
        n_delayed = n_sd_khz >= DELAY_KHZ;

        n_trp = (r_c_q_pc <= 8'd1) ? 8'd1 : r_c_q_pc - 8'd1;
        n_cfg = (r_c_old_cfg & CFG_KEEP_MASK)
              | (32'(n_trp) << 8) | (32'(n_trp) << 24)
              | (32'(r_cas_cycles) << 12) | (32'(r_cas_cycles) << 28)
              | (32'(r_c_q_wr) << 14) | (32'(r_c_q_wr) << 30);

        n_dri = (r_c_sat || r_c_q_ref[17]) ? 12'hfff : r_c_q_ref[16:5];
        n_ref = (r_c_old_ref & REF_KEEP_MASK) | REF_LOW_NIB | (32'(n_half) << 22);
        n_ref = (n_ref & REF_DRI_MASK) | (32'(n_dri) << 4);

        n_r = {r_c_q_rcd, 1'b0} - 9'd1;
        if (r_c_q_rcd == 8'd0) begin
            n_ones  = 32'd0;
            n_shift = 9'(n_delayed);
        end else begin
            n_ones  = (n_r >= 9'd32) ? 32'hffffffff : ~(32'hffffffff << n_r[4:0]);
            n_shift = 9'(n_delayed) + 9'd1 + n_r;
        end
        n_cas0 = n_ones | ((n_shift >= 9'd32) ? 32'd0 : (CAS_BASE << n_shift[4:0]));
        n_cas1 = n_shift[0] ? CAS_BASE_ODD : CAS_BASE;
    end

    always_ff @(posedge i_clk) begin
        r_out_cfg  <= n_cfg;
        r_out_ref  <= n_ref;
        r_out_cas0 <= n_cas0;
        r_out_cas1 <= n_cas1;
        r_out_dri  <= n_dri;
        r_out_half <= n_half;
    end

    assign o_valid            = r_out_vld;
    assign o_config_word      = r_out_cfg;
    assign o_refresh_word     = r_out_ref;
    assign o_cas_pattern_0    = r_out_cas0;
    assign o_cas_pattern_1    = r_out_cas1;
    assign o_cas_pattern_2    = r_out_cas1;
    assign o_refresh_interval = r_out_dri;
    assign o_half_speed       = r_out_half;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("request did not produce a result after 4 cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without a matching request");

    a_ref_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_refresh_word[15:4] == o_refresh_interval)
                    && (o_refresh_word[22] == o_half_speed)
                    && (o_refresh_word[3:0] == 4'h7))
        else $error("refresh word fields disagree with interval or half speed");

    a_cas_low_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cas_pattern_1 == CAS_BASE) || (o_cas_pattern_1 == CAS_BASE_ODD))
        else $error("cas pattern 1 is not an alternating word");
`endif

endmodule
